[design/pwc_pkg.sv]
// Shared types, constants and arithmetic helpers of the particle wing collision block.
package pwc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int A_W = 40;
   localparam int B_W = 34;
   localparam int P_W = A_W + B_W;
   localparam int REQ_W = 224;
   localparam int RSP_W = 224;

   localparam logic signed [A_W-1:0] PUSH_K =
      A_W'(((5 << FRAC_BITS) + 500) / 1000);
   localparam logic signed [B_W-1:0] DAMP_K =
      B_W'(((85 << FRAC_BITS) + 50) / 100);
   localparam logic signed [P_W-1:0] HALF_LSB = P_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [P_W-1:0] S32_MAX = P_W'(2147483647);
   localparam logic signed [P_W-1:0] S32_MIN = ~S32_MAX;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_LEFT_X = 3'd0,
      CSR_BASE_Y = 3'd1,
      CSR_CHORD  = 3'd2,
      CSR_RECIP  = 3'd3,
      CSR_TAN    = 3'd4,
      CSR_SIN    = 3'd5,
      CSR_COS    = 3'd6
   } csr_idx_type;

   // round to nearest, halves upward
   function automatic logic signed [P_W-1:0] round_prod(input logic signed [P_W-1:0] v);
      round_prod = (v + HALF_LSB) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
      if (v > S32_MAX) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [64:0] diff;
      diff = 65'(a) - 65'(b);
      if (diff[64] != diff[63]) begin
         sat_sub64 = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sub64 = diff[63:0];
      end
   endfunction

endpackage

[design/pwc_table.sv]
// Camber and half-thickness table: one write port, one registered read port.
module pwc_table #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [63:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]              rd_data
);
   logic [63:0] mem_ff [DEPTH];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;
endmodule

[design/pwc_mul.sv]
// Shared signed multiplier with registered product.
module pwc_mul (
   input  logic                            clock,
   input  logic signed [pwc_pkg::A_W-1:0] mul_a,
   input  logic signed [pwc_pkg::B_W-1:0] mul_b,
   output logic signed [pwc_pkg::P_W-1:0] prod
);
   import pwc_pkg::*;
   logic signed [P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= P_W'(mul_a) * P_W'(mul_b);
   end

   assign prod = prod_ff;
endmodule

[design/particle_wing_collision.sv]
// Particle against cambered, tilted wing: a step runs up to eleven products
// one after another on the single shared multiplier plus one table read
// (none for a miss outside the chord, for load or for clear).
// Deflected particles update saturating drag and lift sums; one result per
// request transfer. The table holds no valid state: load entries before use.
module particle_wing_collision #(
   parameter int TABLE_POINTS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // entry_index, camber_value, half_thickness, pos_x, pos_y, vel_x, vel_y,
   // mass, zero pad
   input  logic [pwc_pkg::REQ_W-1:0]   req_tdata,
   input  logic [1:0]                  req_tuser,  // command
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // new_y, new_vx, new_vy, drag_total, lift_total
   output logic [pwc_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tuser,  // hit
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   import pwc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_POINTS);
   localparam int HI_W = P_W - FRAC_BITS;
   localparam logic [HI_W-1:0] IDX_MAX = HI_W'(TABLE_POINTS - 2);
   localparam logic [HI_W-1:0] NORM_MAX = HI_W'(1) << FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NORM, ST_IDX, ST_AOA, ST_BOUND, ST_CMP, ST_DOT1, ST_DOT2, ST_DOT3,
      ST_REFX, ST_REFY, ST_REFW, ST_DAMPX, ST_DAMPY, ST_DVX, ST_DVY, ST_LIFT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] wlx_ff, wlx_in, wby_ff, wby_in;
   logic [30:0] chord_ff, chord_in;
   logic [31:0] recip_ff, recip_in;
   logic signed [17:0] tan_ff, tan_in, sin_ff, sin_in, cos_ff, cos_in;
   logic signed [32:0] dx_ff, dx_in;
   logic signed [31:0] py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [23:0] mass_ff, mass_in;
   logic signed [A_W-1:0] upper_ff, upper_in, lower_ff, lower_in;
   logic signed [18:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [P_W-1:0] acc_ff, acc_in;
   logic signed [35:0] d_ff, d_in;
   logic signed [A_W-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic hit_ff, hit_in;
   logic signed [31:0] newy_ff, newy_in, nvx_ff, nvx_in, nvy_ff, nvy_in;
   logic signed [63:0] drag_ff, drag_in, lift_ff, lift_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [6:0] f_index;
   logic signed [31:0] f_camber, f_thick, f_px, f_py, f_vx, f_vy;
   logic [23:0] f_mass;
   logic signed [32:0] dx_c, dvx, dvy;
   logic in_chord, accept, up;
   logic signed [A_W-1:0] mul_a, aoa, py_w;
   logic signed [B_W-1:0] mul_b;
   logic signed [P_W-1:0] prod, rnd;
   logic [HI_W-1:0] prod_hi;
   logic [FRAC_BITS:0] norm;
   logic [IDX_W-1:0] idx;
   logic tbl_we;
   logic [63:0] tbl_rd;
   logic signed [31:0] cam, thk;

   assign f_index  = req_tdata[6:0];
   assign f_camber = req_tdata[38:7];
   assign f_thick  = req_tdata[70:39];
   assign f_px     = req_tdata[102:71];
   assign f_py     = req_tdata[134:103];
   assign f_vx     = req_tdata[166:135];
   assign f_vy     = req_tdata[198:167];
   assign f_mass   = req_tdata[222:199];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign dx_c = 33'(f_px) - 33'(wlx_ff);
   assign in_chord = !dx_c[32] && (dx_c <= $signed({2'b00, chord_ff}));

   assign prod_hi = prod[P_W-1:FRAC_BITS];
   assign norm = (prod_hi > NORM_MAX) ? (FRAC_BITS+1)'(NORM_MAX)
                                      : prod[FRAC_BITS +: FRAC_BITS+1];
   assign idx = (prod_hi > IDX_MAX) ? IDX_W'(IDX_MAX) : prod[FRAC_BITS +: IDX_W];
   assign cam = tbl_rd[31:0];
   assign thk = tbl_rd[63:32];
   assign aoa = A_W'(prod >>> FRAC_BITS);
   assign py_w = A_W'(py_ff);
   assign up = (upper_ff - py_w) < (py_w - lower_ff);
   assign dvx = 33'(nvx_ff) - 33'(vx_ff);
   assign dvy = 33'(nvy_ff) - 33'(vy_ff);

   pwc_table #(.DEPTH(TABLE_POINTS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (IDX_W'(f_index)),
      .wr_data ({f_thick, f_camber}),
      .rd_addr (idx),
      .rd_data (tbl_rd)
   );

   pwc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      state_in = state_ff;
      wlx_in = wlx_ff; wby_in = wby_ff; chord_in = chord_ff; recip_in = recip_ff;
      tan_in = tan_ff; sin_in = sin_ff; cos_in = cos_ff;
      dx_in = dx_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff; mass_in = mass_ff;
      upper_in = upper_ff; lower_in = lower_ff; nx_in = nx_ff; ny_in = ny_ff;
      acc_in = acc_ff; d_in = d_ff; wx_in = wx_ff; wy_in = wy_ff;
      hit_in = hit_ff; newy_in = newy_ff; nvx_in = nvx_ff; nvy_in = nvy_ff;
      drag_in = drag_ff; lift_in = lift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in = rsp_hit_ff; rsp_data_in = rsp_data_ff;
      mul_a = '0; mul_b = '0; tbl_we = 1'b0;
      rnd = '0;

      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LEFT_X: wlx_in = csr_data;
            CSR_BASE_Y: wby_in = csr_data;
            CSR_CHORD:  chord_in = csr_data[30:0];
            CSR_RECIP:  recip_in = csr_data;
            CSR_TAN:    tan_in = csr_data[17:0];
            CSR_SIN:    sin_in = csr_data[17:0];
            CSR_COS:    cos_in = csr_data[17:0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dx_in = dx_c; py_in = f_py; vx_in = f_vx; vy_in = f_vy; mass_in = f_mass;
               hit_in = 1'b0; newy_in = f_py; nvx_in = f_vx; nvy_in = f_vy;
               state_in = ST_FINISH;
               unique case (cmd_type'(req_tuser))
                  CMD_LOAD:  tbl_we = (32'(f_index) < TABLE_POINTS);
                  CMD_CLEAR: begin
                     drag_in = '0;
                     lift_in = '0;
                  end
                  CMD_STEP:  if (in_chord) state_in = ST_NORM;
                  default:   ;
               endcase
            end
         end
         ST_NORM: begin
            mul_a = A_W'(dx_ff);
            mul_b = $signed({2'b00, recip_ff});
            state_in = ST_IDX;
         end
         ST_IDX: begin
            mul_a = $signed(A_W'(norm));
            mul_b = $signed(B_W'(TABLE_POINTS - 1));
            state_in = ST_AOA;
         end
         ST_AOA: begin
            mul_a = A_W'(dx_ff);
            mul_b = B_W'(tan_ff);
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            upper_in = A_W'(wby_ff) + A_W'(cam) + A_W'(thk) - aoa;
            lower_in = A_W'(wby_ff) + A_W'(cam) - A_W'(thk) - aoa;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (py_w >= lower_ff && py_w <= upper_ff) begin
               hit_in = 1'b1;
               nx_in = up ? 19'(sin_ff) : -19'(sin_ff);
               ny_in = up ? 19'(cos_ff) : -19'(cos_ff);
               newy_in = sat32(P_W'(up ? upper_ff + PUSH_K : lower_ff - PUSH_K));
               state_in = ST_DOT1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DOT1: begin
            mul_a = A_W'(vx_ff);
            mul_b = B_W'(nx_ff);
            state_in = ST_DOT2;
         end
         ST_DOT2: begin
            acc_in = prod;
            mul_a = A_W'(vy_ff);
            mul_b = B_W'(ny_ff);
            state_in = ST_DOT3;
         end
         ST_DOT3: begin
            rnd = round_prod(acc_ff + prod);
            d_in = rnd[35:0];
            if (rnd[P_W-1]) begin
               state_in = ST_REFX;
            end else begin
               wx_in = A_W'(vx_ff);
               wy_in = A_W'(vy_ff);
               state_in = ST_DAMPX;
            end
         end
         ST_REFX: begin
            mul_a = A_W'(d_ff);
            mul_b = B_W'(nx_ff);
            state_in = ST_REFY;
         end
         ST_REFY: begin
            rnd = round_prod(prod <<< 1);
            wx_in = A_W'(vx_ff) - rnd[A_W-1:0];
            mul_a = A_W'(d_ff);
            mul_b = B_W'(ny_ff);
            state_in = ST_REFW;
         end
         ST_REFW: begin
            rnd = round_prod(prod <<< 1);
            wy_in = A_W'(vy_ff) - rnd[A_W-1:0];
            state_in = ST_DAMPX;
         end
         ST_DAMPX: begin
            mul_a = wx_ff;
            mul_b = DAMP_K;
            state_in = ST_DAMPY;
         end
         ST_DAMPY: begin
            nvx_in = sat32(round_prod(prod));
            mul_a = wy_ff;
            mul_b = DAMP_K;
            state_in = ST_DVX;
         end
         ST_DVX: begin
            nvy_in = sat32(round_prod(prod));
            mul_a = A_W'(dvx);
            mul_b = $signed(B_W'(mass_ff));
            state_in = ST_DVY;
         end
         ST_DVY: begin
            drag_in = sat_sub64(drag_ff, prod[63:0]);
            mul_a = A_W'(dvy);
            mul_b = $signed(B_W'(mass_ff));
            state_in = ST_LIFT;
         end
         ST_LIFT: begin
            lift_in = sat_sub64(lift_ff, prod[63:0]);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_data_in = {lift_ff, drag_ff, nvy_ff, nvx_ff, newy_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wlx_ff <= '0;
         wby_ff <= '0;
         chord_ff <= 31'(1) << FRAC_BITS;
         recip_ff <= 32'(1) << FRAC_BITS;
         tan_ff <= '0;
         sin_ff <= '0;
         cos_ff <= 18'(1) << FRAC_BITS;
         drag_ff <= '0;
         lift_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wlx_ff <= wlx_in;
         wby_ff <= wby_in;
         chord_ff <= chord_in;
         recip_ff <= recip_in;
         tan_ff <= tan_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
         drag_ff <= drag_in;
         lift_ff <= lift_in;
      end
      dx_ff <= dx_in; py_ff <= py_in; vx_ff <= vx_in; vy_ff <= vy_in; mass_ff <= mass_in;
      upper_ff <= upper_in; lower_ff <= lower_in; nx_ff <= nx_in; ny_ff <= ny_in;
      acc_ff <= acc_in; d_ff <= d_in; wx_ff <= wx_in; wy_ff <= wy_in;
      hit_ff <= hit_in; newy_ff <= newy_in; nvx_ff <= nvx_in; nvy_ff <= nvy_in;
      rsp_hit_ff <= rsp_hit_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_hit_ff;
endmodule

[design/pwc_checker.sv]
// Port-level checks of the particle wing collision block, bound to the top level.
module pwc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [pwc_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared in the cycle after request transfer");
endmodule

bind particle_wing_collision pwc_checker u_pwc_checker (.*);
